>>> design/tick_rate_calibrated_msec_clock_macros.svh
// Assertion macros used by the checker file of the calibrated millisecond clock.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef TICK_RATE_CALIBRATED_MSEC_CLOCK_MACROS_SVH
`define TICK_RATE_CALIBRATED_MSEC_CLOCK_MACROS_SVH

// Property checked at every rising edge, switched off while reset is held.
`define TRMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked at every rising edge, reset included.
`define TRMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/tcmc_pkg.sv
// Types and constants of the tick-rate calibrated millisecond clock.
// No dependencies; used by the top level and by its checker.
`timescale 1ns / 1ps

package tcmc_pkg;

    localparam int TICK_IN_W   = 63;   // tick_sample field width
    localparam int MS_W        = 32;   // millisecond fields
    localparam int CFG_W       = 10;   // configuration register width
    localparam int IN_TDATA_W  = 96;   // 63 + 32 bits, padded to whole bytes
    localparam int OUT_TDATA_W = 32;

    localparam logic [CFG_W-1:0] RESYNC_LIMIT_RST = 10'd100;
    localparam logic [CFG_W-1:0] MIN_ADJUST_RST   = 10'd10;

    typedef enum logic [0:0] {
        CFG_RESYNC_LIMIT = 1'b0,
        CFG_MIN_ADJUST   = 1'b1
    } tcmc_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SIGN,
        ST_ADV
    } tcmc_state_t;

endpackage

>>> design/tick_rate_calibrated_msec_clock.sv
// Top level of the tick-rate calibrated millisecond clock.
// Depends on tcmc_pkg; the checker in tcmc_checker.sv binds to it.
`timescale 1ns / 1ps

// Each input word carries a cycle-counter sample and a millisecond reading
// from a slow clock, and each produces exactly one output word. When the
// sample is still below the predicted next tick, the last millisecond value
// is answered again with tuser low and the reading is dropped. Otherwise the
// reading is answered with tuser high and the calibration state moves on: a
// gap from the base millisecond above resync_limit_ms restarts calibration,
// and a gap of at least min_adjust_ms re-estimates the ticks per millisecond
// by a signed division that truncates toward zero. Every word is evaluated
// after it is taken, and at the end of evaluation its answer is written
// to the output register. A word that needs no new rate estimate returns
// to idle after evaluation and then lets the next word in. A word that
// re-estimates the rate is not followed by another word until it has gone
// through evaluation, a restoring divider that produces one quotient bit
// per cycle through a shift register, a step that applies the sign, a step
// that advances the prediction and the return to idle. The answer can be
// taken while the divider runs. If the output register is still full,
// evaluation waits until it is taken.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while the block is idle.
module tick_rate_calibrated_msec_clock #(
    parameter int TICK_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream. tdata, from bit 0: tick_sample[62:0], elapsed_ms[94:63], zero pad.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tcmc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Output stream. tdata, from bit 0: ms_value[31:0]. tuser, bit 0: refreshed.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tcmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                              m_axis_tuser,
    // Configuration writes: index 0 is resync_limit_ms, index 1 is min_adjust_ms.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [tcmc_pkg::CFG_W-1:0]        cfg_data
);
    import tcmc_pkg::*;

    localparam int CNT_W = $clog2(TICK_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TICK_BITS - 1);

    // Control state.
    tcmc_state_t            state_reg, state_next;
    logic [CFG_W-1:0]       resync_reg, min_reg;
    logic                   m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;

    // Calibration state.
    logic [MS_W-1:0]        base_ms_reg, base_ms_next;
    logic [TICK_BITS-1:0]   base_tick_reg, base_tick_next;
    logic [TICK_BITS-1:0]   ticks_reg, ticks_next;
    logic [TICK_BITS-1:0]   pred_reg, pred_next;
    logic [MS_W-1:0]        cached_reg, cached_next;

    // Payload and divider registers.
    logic [TICK_BITS-1:0]   tick_reg, tick_next;
    logic [MS_W-1:0]        now_reg, now_next;
    logic [TICK_BITS-1:0]   dvd_reg, dvd_next;
    logic [CFG_W-1:0]       rem_reg, rem_next;
    logic [CFG_W-1:0]       den_reg, den_next;
    logic                   neg_reg, neg_next;
    logic [MS_W-1:0]        m_ms_reg, m_ms_next;
    logic                   m_ref_reg, m_ref_next;

    // Decode of the current item.
    logic                   in_fire;
    logic                   out_free;
    logic                   eval_go;
    logic                   hit_cache;
    logic [MS_W-1:0]        gap;
    logic [CFG_W-1:0]       min_gap;
    logic                   over_limit;
    logic                   adjust;
    logic [TICK_BITS-1:0]   diff;
    logic [TICK_BITS-1:0]   mag;
    logic [CFG_W:0]         trial;
    logic [CFG_W:0]         trial_sub;
    logic                   q_bit;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_ms_reg;
    assign m_axis_tuser  = m_ref_reg;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // A stored min of zero acts as one so the divisor never becomes zero.
    assign min_gap    = (min_reg == '0) ? CFG_W'(1) : min_reg;
    assign hit_cache  = $signed(tick_reg) < $signed(pred_reg);
    assign gap        = now_reg - base_ms_reg;
    assign over_limit = gap > {{(MS_W-CFG_W){1'b0}}, resync_reg};
    assign adjust     = gap >= {{(MS_W-CFG_W){1'b0}}, min_gap};
    assign diff       = tick_reg - base_tick_reg;
    assign mag        = diff[TICK_BITS-1] ? (~diff + TICK_BITS'(1)) : diff;

    // One restoring step: the remainder stays below the divisor, so the
    // trial value fits one bit more than the divisor.
    assign trial     = {rem_reg, dvd_reg[TICK_BITS-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign q_bit     = trial >= {1'b0, den_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    if (!hit_cache && !over_limit && adjust)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_ADV;
            end
            ST_ADV:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        s_axis_tready = 1'b0;
        eval_go       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_EVAL:
            begin
                eval_go = out_free;
            end
            ST_DIV, ST_SIGN, ST_ADV:
            begin
                s_axis_tready = 1'b0;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        tick_next      = tick_reg;
        now_next       = now_reg;
        base_ms_next   = base_ms_reg;
        base_tick_next = base_tick_reg;
        ticks_next     = ticks_reg;
        pred_next      = pred_reg;
        cached_next    = cached_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        m_ms_next      = m_ms_reg;
        m_ref_next     = m_ref_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;

        if (in_fire)
        begin
            tick_next = TICK_BITS'({1'b0, s_axis_tdata[TICK_IN_W-1:0]});
            now_next  = s_axis_tdata[TICK_IN_W+MS_W-1:TICK_IN_W];
        end

        if (eval_go)
        begin
            m_valid_next = 1'b1;
            if (hit_cache)
            begin
                // Prediction not reached yet: answer the last value again.
                m_ms_next  = cached_reg;
                m_ref_next = 1'b0;
            end
            else
            begin
                m_ms_next   = now_reg;
                m_ref_next  = 1'b1;
                cached_next = now_reg;
                if (over_limit)
                begin
                    base_ms_next   = now_reg;
                    base_tick_next = tick_reg;
                    ticks_next     = '0;
                    pred_next      = '0;
                end
                else if (adjust)
                begin
                    // The gap is at most the resync limit here, so it fits
                    // the divisor register.
                    base_ms_next   = now_reg;
                    base_tick_next = tick_reg;
                    dvd_next       = mag;
                    neg_next       = diff[TICK_BITS-1];
                    den_next       = gap[CFG_W-1:0];
                    rem_next       = '0;
                    cnt_next       = '0;
                end
                else
                begin
                    pred_next = pred_reg + ticks_reg;
                end
            end
        end

        case (state_reg)
            ST_DIV:
            begin
                rem_next = q_bit ? trial_sub[CFG_W-1:0] : trial[CFG_W-1:0];
                dvd_next = {dvd_reg[TICK_BITS-2:0], q_bit};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_SIGN:
            begin
                ticks_next = neg_reg ? (~dvd_reg + TICK_BITS'(1)) : dvd_reg;
            end
            ST_ADV:
            begin
                // The base tick now equals the sample of this word.
                pred_next = base_tick_reg + ticks_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            resync_reg    <= RESYNC_LIMIT_RST;
            min_reg       <= MIN_ADJUST_RST;
            base_ms_reg   <= '0;
            base_tick_reg <= '0;
            ticks_reg     <= '0;
            pred_reg      <= '0;
            cached_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            cnt_reg       <= cnt_next;
            base_ms_reg   <= base_ms_next;
            base_tick_reg <= base_tick_next;
            ticks_reg     <= ticks_next;
            pred_reg      <= pred_next;
            cached_reg    <= cached_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_RESYNC_LIMIT:
                    begin
                        resync_reg <= cfg_data;
                    end
                    CFG_MIN_ADJUST:
                    begin
                        min_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tick_reg  <= tick_next;
        now_reg   <= now_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        neg_reg   <= neg_next;
        m_ms_reg  <= m_ms_next;
        m_ref_reg <= m_ref_next;
    end

endmodule

>>> design/tcmc_checker.sv
// Port-level checker for the tick-rate calibrated millisecond clock, with its bind.
// Depends on tcmc_pkg and tick_rate_calibrated_msec_clock_macros.svh.
`timescale 1ns / 1ps
`include "tick_rate_calibrated_msec_clock_macros.svh"

module tcmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tcmc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tuser
);
    import tcmc_pkg::*;

    logic [1:0]      pend_reg, pend_next;
    logic [MS_W-1:0] last_ms_reg, last_ms_next;
    logic            in_fire, out_fire;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // Words taken in but not yet delivered, and the last refreshed answer.
    always_comb
    begin
        pend_next    = pend_reg + {1'b0, in_fire} - {1'b0, out_fire};
        last_ms_next = (out_fire && m_axis_tuser) ? m_axis_tdata[MS_W-1:0] : last_ms_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            last_ms_reg <= '0;
        end
        else
        begin
            pend_reg    <= pend_next;
            last_ms_reg <= last_ms_next;
        end
    end

    `TRMC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !m_axis_tvalid, "output valid during reset")
    `TRMC_ASSERT(a_no_invented, m_axis_tvalid |-> pend_reg != 2'd0, "word shown with none pending")
    `TRMC_ASSERT(a_bounded, pend_reg != 2'd3, "more than two words in flight")
    `TRMC_ASSERT(a_cached, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == last_ms_reg, "cached answer differs from last refreshed value")
    `TRMC_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "output word changed while stalled")

endmodule

bind tick_rate_calibrated_msec_clock tcmc_checker u_tcmc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/tick_rate_calibrated_msec_clock_tb.sv
// Self-checking testbench for the tick-rate calibrated millisecond clock.
// Depends on tcmc_pkg and the tick_rate_calibrated_msec_clock top level only.
`timescale 1ns / 1ps

module tick_rate_calibrated_msec_clock_tb;

    import tcmc_pkg::*;

    // Cycle limit that stops a hung run; a correct run stays well below it.
    localparam int CYCLE_LIMIT = 1000000;
    // A rate estimate keeps the block busy from the edge where its word is
    // taken through the division that follows its answer, so every quiet
    // period waits longer than the whole estimate.
    localparam int SETTLE_CYCLES = 100;
    localparam int WALK_ITEMS = 122;
    localparam int PHASES = 6;
    localparam logic [TICK_IN_W-1:0] TICK_MAX = {TICK_IN_W{1'b1}};

    typedef struct packed {
        logic [MS_W-1:0] ms_value;
        logic            refreshed;
    } clock_answer_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_RESYNC_LIMIT;
    logic [CFG_W-1:0]       cfg_data = '0;

    tick_rate_calibrated_msec_clock dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // Mirror of the configuration registers, updated when a write is taken.
    logic [CFG_W-1:0] resync_lim = RESYNC_LIMIT_RST;
    logic [CFG_W-1:0] adj_min    = MIN_ADJUST_RST;

    // Calibration state of the predictor, at the full 64-bit tick width.
    logic [MS_W-1:0] cal_base_ms   = '0;
    logic [63:0]     cal_base_tick = '0;
    logic [63:0]     cal_rate      = '0;
    logic [63:0]     cal_next_tick = '0;
    logic [MS_W-1:0] cal_last_ms   = '0;

    logic [IN_TDATA_W-1:0] words_to_send[$];
    clock_answer_t         answers_due[$];
    clock_answer_t         answer_seen;

    int mismatches = 0;
    int words_taken = 0;
    int cycle_cnt = 0;
    int tx_pause = 0;
    int rx_pause = 0;
    bit brisk = 1'b0;
    int brisk_left = 0;
    bit hold_off = 1'b0;

    // Random walk that the well-formed sequences follow.
    logic [TICK_IN_W-1:0] walk_tick = '0;
    logic [MS_W-1:0]      walk_ms = '0;
    logic [63:0]          walk_rate = 64'd1000;

    // Works out the answer to one word and moves the calibration on. Tick
    // comparisons are signed; the sample itself is always non-negative since
    // it is zero-extended from 63 bits, but the prediction may be negative.
    function automatic clock_answer_t advance_clock(input logic [TICK_IN_W-1:0] sample,
                                                    input logic [MS_W-1:0] now);
        logic [63:0]     tick;
        logic [63:0]     diff;
        logic [63:0]     mag;
        logic [MS_W-1:0] span;
        logic [MS_W-1:0] floor_gap;
        clock_answer_t   ans;
        tick = {1'b0, sample};
        floor_gap = (adj_min == '0) ? 32'd1 : {22'd0, adj_min};
        if ($signed(tick) < $signed(cal_next_tick)) begin
            ans.ms_value = cal_last_ms;
            ans.refreshed = 1'b0;
            return ans;
        end
        span = now - cal_base_ms;
        if (span > {22'd0, resync_lim}) begin
            // Too long since the base: drop the calibration and start over.
            cal_base_ms = now;
            cal_base_tick = tick;
            cal_next_tick = '0;
            cal_rate = '0;
        end
        else if (span >= floor_gap) begin
            // Signed rate estimate, truncated toward zero.
            diff = tick - cal_base_tick;
            mag = diff[63] ? (64'd0 - diff) : diff;
            mag = mag / {32'd0, span};
            cal_rate = diff[63] ? (64'd0 - mag) : mag;
            cal_base_ms = now;
            cal_base_tick = tick;
            cal_next_tick = tick;
        end
        cal_next_tick = cal_next_tick + cal_rate;
        cal_last_ms = now;
        ans.ms_value = now;
        ans.refreshed = 1'b1;
        return ans;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [TICK_IN_W-1:0] rand_tick();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TICK_IN_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("ERROR at %0t ns: %s", $time, what);
    endtask

    task automatic push_word(input logic [TICK_IN_W-1:0] tick, input logic [MS_W-1:0] ms);
        words_to_send.push_back({1'b0, ms, tick});
    endtask

    // Queues n words, most of them a plausible clock walk with random content:
    // the tick runs at roughly walk_rate per millisecond, gaps range over both
    // thresholds, and a repeated millisecond usually lands below the
    // prediction. The rest run the counter backward or are plain noise.
    task automatic queue_walk(input int n);
        int sel;
        int step;
        logic [63:0] adv;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
                walk_rate = 64'($urandom_range(1, 1000000));
            if (sel < 78)
            begin
                case ($urandom_range(0, 3))
                    0: step = $urandom_range(0, 2);
                    1: step = $urandom_range(adj_min, adj_min + 3);
                    2: step = $urandom_range(0, resync_lim);
                    default: step = $urandom_range(resync_lim, resync_lim + 50);
                endcase
                adv = 64'(step) * walk_rate;
                if ($urandom_range(0, 1) == 0)
                    adv = adv + 64'($urandom_range(0, walk_rate));
                else if (adv > walk_rate)
                    adv = adv - 64'($urandom_range(0, walk_rate));
                walk_ms = walk_ms + MS_W'(step);
                walk_tick = walk_tick + adv[TICK_IN_W-1:0];
            end
            else if (sel < 90)
            begin
                walk_ms = walk_ms + MS_W'($urandom_range(0, resync_lim));
                walk_tick = walk_tick - TICK_IN_W'($urandom_range(0, 1000000));
            end
            else
            begin
                walk_tick = rand_tick();
                walk_ms = $urandom;
            end
            push_word(walk_tick, walk_ms);
        end
    endtask

    task automatic write_reg(input tcmc_cfg_idx_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_RESYNC_LIMIT)
            resync_lim = val;
        else
            adj_min = val;
    endtask

    // Returns once every queued word has been taken and answered, plus enough
    // cycles for a division still running behind the last answer. The check
    // is made at the falling edge, when the sender's updates have settled.
    task automatic drain();
        while (words_to_send.size() != 0 || s_axis_tvalid || answers_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stretches in which neither side idles.
    always @(posedge clk)
    begin
        if (brisk_left == 0)
        begin
            brisk <= ($urandom_range(0, 3) == 0);
            brisk_left <= $urandom_range(50, 300);
        end
        else
        begin
            brisk_left <= brisk_left - 1;
        end
    end

    // Sender: offers queued words with random gaps. The answer for a word is
    // predicted at the edge where the word is taken, which keeps the
    // expectations in acceptance order.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            tx_pause <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                answers_due.push_back(advance_clock(s_axis_tdata[TICK_IN_W-1:0],
                                                    s_axis_tdata[TICK_IN_W+MS_W-1:TICK_IN_W]));
                words_taken <= words_taken + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (tx_pause > 0)
                begin
                    tx_pause <= tx_pause - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (words_to_send.size() != 0)
                begin
                    s_axis_tdata <= words_to_send.pop_front();
                    s_axis_tvalid <= 1'b1;
                    tx_pause <= brisk ? 0 : pause_len();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stalls at random, or for a long stretch when hold_off is set,
    // and checks each answer word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_pause <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_due.size() == 0)
                begin
                    flag_mismatch($sformatf("answer word ms=%0h with nothing expected",
                                            m_axis_tdata));
                end
                else
                begin
                    answer_seen = answers_due.pop_front();
                    if (m_axis_tdata !== answer_seen.ms_value)
                        flag_mismatch($sformatf("ms_value %0h, expected %0h",
                                                m_axis_tdata, answer_seen.ms_value));
                    if (m_axis_tuser !== answer_seen.refreshed)
                        flag_mismatch($sformatf("refreshed %0b, expected %0b (ms %0h)",
                                                m_axis_tuser, answer_seen.refreshed,
                                                answer_seen.ms_value));
                end
            end
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
            end
            else if (rx_pause > 0)
            begin
                rx_pause <= rx_pause - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                rx_pause <= brisk ? 0 : pause_len();
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off during the first random phase, so that the output
    // register fills and the block has to close its input.
    initial
    begin
        while (words_taken < 100)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tick_rate_calibrated_msec_clock test failed");
            $finish;
        end
    end

    // Settings per random phase: wide limit with the smallest minimum, both at
    // one, minimum above the limit, both at 1000, a zero minimum, random.
    int lim_plan[PHASES] = '{1000, 1, 37, 1000, 300, 0};
    int min_plan[PHASES] = '{1, 1, 200, 1000, 0, 0};

    initial
    begin
        // Reset goes low once every process is waiting, so it gives a clean edge.
        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings (limit 100, minimum 10).
        push_word('0, 32'd0);                  // tick equal to a zero prediction
        push_word(63'd1000, 32'd5);            // gap below the minimum
        push_word(63'd10000, 32'd10);          // first rate estimate
        push_word(63'd10500, 32'd10);          // below the prediction: cached answer
        push_word(63'd11000, 32'd11);          // exactly on the prediction
        push_word(63'd31000, 32'd30);          // rate re-estimated
        push_word(63'd20000, 32'd40);          // below the prediction again
        push_word(63'd40000, 32'd500);         // gap over the limit: resync
        push_word(63'd30000, 32'd520);         // backward ticks, negative rate
        push_word(63'd29600, 32'd533);         // negative quotient truncated
        push_word(TICK_MAX, 32'hFFFF_FFFF);    // both fields at their maximum
        push_word('0, 32'd9);                  // millisecond wrap, huge negative rate
        push_word(TICK_MAX, 32'd31);           // huge positive rate, prediction wraps
        push_word('0, 32'd32);
        push_word({31'h2AAA_AAAA, 32'hAAAA_AAAA}, 32'h5555_5555);
        push_word({31'h5555_5555, 32'h5555_5555}, 32'hAAAA_AAAA);
        push_word({31'h5555_5555, 32'h5555_5600}, 32'hAAAA_AAB0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                lim_plan[p] = $urandom_range(1, 1000);
                min_plan[p] = $urandom_range(1, 1000);
            end
            write_reg(CFG_RESYNC_LIMIT, CFG_W'(lim_plan[p]));
            write_reg(CFG_MIN_ADJUST, CFG_W'(min_plan[p]));
            queue_walk(WALK_ITEMS);
            drain();
        end

        if (mismatches == 0)
            $display("tick_rate_calibrated_msec_clock test passed");
        else
            $display("tick_rate_calibrated_msec_clock test failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/tcmc_pkg.sv
design/tick_rate_calibrated_msec_clock.sv
design/tcmc_checker.sv
tb/tick_rate_calibrated_msec_clock_tb.sv
